FILE: sv/dsns_pkg.sv
// dsns_pkg: shared types and constants of the steep-neighbor selector
// register indexes, fixed field widths and reset values of the registers
// no dependencies
package dsns_pkg;

	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int HEIGHT_BITS_DEF = 16;

	localparam int DIM_BITS        = 13;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int OUT_HEIGHT_BITS = 16;
	localparam int CNT_BITS        = 25;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_RISE_THRESHOLD,
		REG_NO_DATA_CODE
	} cfg_reg_t;

	localparam logic [DIM_BITS-1:0]      WIDTH_RESET     = 13'd4096;
	localparam logic [DIM_BITS-1:0]      HEIGHT_RESET    = 13'd4096;
	localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RESET = 16'd0;
	localparam logic [CFG_DATA_BITS-1:0] NO_DATA_RESET   = 16'h8000;

endpackage

FILE: sv/dsns_in_if.sv
// dsns_in_if: valid/ready channel that carries elevation sample items
// depends on dsns_pkg for the default sample width
interface dsns_in_if
	import dsns_pkg::*;
#(
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [HEIGHT_BITS-1:0] height;
	logic                          already_marked;

	modport source (output valid, output command, output height, output already_marked,
		input ready);
	modport sink (input valid, input command, input height, input already_marked,
		output ready);
endinterface

FILE: sv/dsns_out_if.sv
// dsns_out_if: valid/ready channel that carries selection result items
// depends on dsns_pkg for the fixed result widths
interface dsns_out_if
	import dsns_pkg::*;
;
	logic                              valid;
	logic                              ready;
	logic                              selected;
	logic                              newly_added;
	logic signed [OUT_HEIGHT_BITS-1:0] out_height;
	logic        [CNT_BITS-1:0]        added_total;
	logic                              frame_end;

	modport source (output valid, output selected, output newly_added, output out_height,
		output added_total, output frame_end, input ready);
	modport sink (input valid, input selected, input newly_added, input out_height,
		input added_total, input frame_end, output ready);
endinterface

FILE: sv/dsns_ram.sv
// dsns_ram: generic one-write one-read memory with registered read data
// read during a write to the same address returns the old contents
// no dependencies
module dsns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: sv/dem_steep_neighbor_select.sv
// dem_steep_neighbor_select: top level of the steep-neighbor selector
// depends on dsns_pkg, dsns_in_if, dsns_out_if and dsns_ram
//
// Usage: elevation samples enter on the sample channel in raster order, one
// item per grid position, each with a flag telling whether the output grid
// already holds a point there. A sample is selected when one of its valid
// north, south, east or west neighbors differs by more than rise_threshold.
// Results trail the input by one grid row, so the first row gives no result
// and flush items (command = 1) supply the row below the bottom edge; the
// result of the last position carries frame_end and the added count restarts.
// Timing: one item per clock unless the receiver stalls. An accepted item that yields a
// result passes through the working stage and the result register to the result channel.
// The rate is set by two line buffers (dsns_ram) read one position ahead with a registered read.
// When the receiver stalls, one more item is taken into the working stage and
// then sample.ready drops until the result register empties.
// Reset: position, counters and registers return to their reset values at
// once; the line buffers are not cleared, their stale entries are never used.
// Registers must be written through cfg_we / cfg_index / cfg_data only while idle; the block does not enforce it.
module dem_steep_neighbor_select
	import dsns_pkg::*;
#(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	dsns_in_if.sink                   sample,
	dsns_out_if.source                result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);
	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int WB       = $clog2(MAX_WIDTH + 1);
	localparam int WCMP     = (WB > DIM_BITS) ? WB : DIM_BITS;
	localparam int SW       = (HEIGHT_BITS > CFG_DATA_BITS) ? HEIGHT_BITS : CFG_DATA_BITS;
	localparam int AW       = 2 * SW + 1;

	// configuration
	logic        [DIM_BITS-1:0]      width_q, height_q;
	logic        [CFG_DATA_BITS-1:0] thr_q;
	logic signed [CFG_DATA_BITS-1:0] nd_q;
	logic        [DIM_BITS-1:0]      width_d;
	logic signed [SW-1:0]            nd_ext;

	// position state
	logic [COL_BITS-1:0] col_q, col_d;
	logic [DIM_BITS-1:0] row_q, row_d;
	logic signed [SW-1:0] tap_left_q;
	logic [CNT_BITS-1:0] cnt_q, cnt_next;

	// line buffer access
	logic [COL_BITS-1:0] rd_addr_a, rd_addr_b;
	logic [AW-1:0]       ram_a_rd, ram_a_wr;
	logic [SW-1:0]       ram_b_rd;
	logic                byp_a_q, byp_b_q;
	logic signed [SW-1:0] wr_centre_q, wr_below_q;
	logic                wr_mark_q;

	// item entry
	logic                acc;
	logic [WB-1:0]       w_cur, w_d;
	logic [DIM_BITS-1:0] h_cur;
	logic [COL_BITS-1:0] c;
	logic [WB-1:0]       c_inc;
	logic                flush, at_end, last, no_sample, mark_in;
	logic signed [SW-1:0] below, centre, up, right;
	logic                mark_above;

	// working stage
	logic                 valid_s1, produce_s1, last_s1, mark_s1;
	logic                 has_left_s1, has_right_s1, has_up_s1, has_below_s1;
	logic signed [SW-1:0] centre_s1, left_s1, right_s1, up_s1, below_s1;
	logic                 adv_s1, sel, fresh;

	// result register
	logic                              out_valid_q;
	logic                              selected_q, newly_added_q, frame_end_q;
	logic signed [OUT_HEIGHT_BITS-1:0] out_height_q;
	logic        [CNT_BITS-1:0]        added_total_q;

	function automatic logic [WB-1:0] eff_width(logic [DIM_BITS-1:0] v);
		logic [WCMP-1:0] x;
		x = WCMP'(v);
		if (x == '0) begin
			return WB'(1);
		end
		if (x > WCMP'(MAX_WIDTH)) begin
			return WB'(MAX_WIDTH);
		end
		return x[WB-1:0];
	endfunction

	function automatic logic [COL_BITS-1:0] clamp_col(logic [COL_BITS-1:0] col,
			logic [WB-1:0] w);
		if (WB'(col) >= w) begin
			return COL_BITS'(w - WB'(1));
		end
		return col;
	endfunction

	function automatic logic steep(logic signed [SW-1:0] ctr, logic signed [SW-1:0] nb,
			logic has_nb);
		logic signed [SW:0] d;
		logic        [SW:0] mag;
		d   = (SW+1)'(ctr) - (SW+1)'(nb);
		mag = d[SW] ? $unsigned(-d) : $unsigned(d);
		return has_nb && (nb != nd_ext) && (mag > (SW+1)'(thr_q));
	endfunction

	assign nd_ext = SW'(nd_q);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thr_q    <= THRESHOLD_RESET;
			nd_q     <= NO_DATA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:    width_q  <= cfg_data[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_data[DIM_BITS-1:0];
				REG_RISE_THRESHOLD: thr_q    <= cfg_data;
				REG_NO_DATA_CODE:   nd_q     <= cfg_data;
				default:            width_q  <= width_q;
			endcase
		end
	end

	assign width_d = (cfg_we && cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH)
		? cfg_data[DIM_BITS-1:0] : width_q;

	// entry of an item: neighbors from the line buffers, next position
	assign sample.ready = !valid_s1 || adv_s1;
	assign acc          = sample.valid && sample.ready;

	always_comb begin
		w_cur     = eff_width(width_q);
		w_d       = eff_width(width_d);
		h_cur     = (height_q == '0) ? DIM_BITS'(1) : height_q;
		c         = clamp_col(col_q, w_cur);
		c_inc     = WB'(c) + WB'(1);
		at_end    = c_inc >= w_cur;
		flush     = row_q >= h_cur;
		last      = flush && at_end;
		no_sample = flush || sample.command;
		below     = no_sample ? nd_ext : SW'(sample.height);
		mark_in   = no_sample ? 1'b0 : sample.already_marked;

		// the write of the previous edge may not be in the read data yet
		up         = byp_a_q ? wr_centre_q : ram_a_rd[AW-1 -: SW];
		centre     = byp_a_q ? wr_below_q  : ram_a_rd[SW:1];
		mark_above = byp_a_q ? wr_mark_q   : ram_a_rd[0];
		right      = byp_b_q ? wr_below_q  : ram_b_rd;

		col_d = col_q;
		row_d = row_q;
		if (acc) begin
			if (last) begin
				col_d = '0;
				row_d = '0;
			end else if (at_end) begin
				col_d = '0;
				row_d = row_q + DIM_BITS'(1);
			end else begin
				col_d = c_inc[COL_BITS-1:0];
			end
		end

		// read one position ahead so data is ready when the next item arrives
		rd_addr_a = clamp_col(col_d, w_d);
		rd_addr_b = rd_addr_a + COL_BITS'(1);
	end

	assign ram_a_wr = {centre, below, mark_in};

	dsns_ram #(
		.WIDTH (AW),
		.DEPTH (MAX_WIDTH)
	) u_rows_ram (
		.clk   (clk),
		.we    (acc),
		.waddr (c),
		.wdata (ram_a_wr),
		.raddr (rd_addr_a),
		.rdata (ram_a_rd)
	);

	// second copy of the row above, for the east neighbor
	dsns_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_WIDTH)
	) u_east_ram (
		.clk   (clk),
		.we    (acc),
		.waddr (c),
		.wdata (below),
		.raddr (rd_addr_b),
		.rdata (ram_b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			tap_left_q <= '0;
			byp_a_q    <= 1'b0;
			byp_b_q    <= 1'b0;
			valid_s1   <= 1'b0;
		end else begin
			col_q   <= col_d;
			row_q   <= row_d;
			byp_a_q <= acc && (rd_addr_a == c);
			byp_b_q <= acc && (rd_addr_b == c);
			if (acc) begin
				tap_left_q <= centre;
				valid_s1   <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			wr_centre_q  <= centre;
			wr_below_q   <= below;
			wr_mark_q    <= mark_in;
			centre_s1    <= centre;
			left_s1      <= tap_left_q;
			right_s1     <= right;
			up_s1        <= up;
			below_s1     <= below;
			has_left_s1  <= c != '0;
			has_right_s1 <= !at_end;
			has_up_s1    <= row_q > DIM_BITS'(1);
			has_below_s1 <= !flush;
			produce_s1   <= row_q != '0;
			last_s1      <= last;
			mark_s1      <= mark_above;
		end
	end

	// working stage: neighbor compares and the added count
	assign adv_s1 = valid_s1 && (!produce_s1 || !out_valid_q || result.ready);

	always_comb begin
		sel = (centre_s1 != nd_ext)
			&& (steep(centre_s1, left_s1, has_left_s1)
			|| steep(centre_s1, right_s1, has_right_s1)
			|| steep(centre_s1, up_s1, has_up_s1)
			|| steep(centre_s1, below_s1, has_below_s1));
		fresh    = sel && !mark_s1;
		cnt_next = (fresh && cnt_q != '1) ? cnt_q + CNT_BITS'(1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1 && produce_s1) begin
				cnt_q       <= last_s1 ? '0 : cnt_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && produce_s1) begin
			selected_q    <= sel;
			newly_added_q <= fresh;
			out_height_q  <= centre_s1[OUT_HEIGHT_BITS-1:0];
			added_total_q <= cnt_next;
			frame_end_q   <= last_s1;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.selected    = selected_q;
	assign result.newly_added = newly_added_q;
	assign result.out_height  = out_height_q;
	assign result.added_total = added_total_q;
	assign result.frame_end   = frame_end_q;
endmodule
